>>> rtl/core/dks_pkg.sv
package dks_pkg;

  localparam int KEY_W       = 64;
  localparam int CD_W        = 56;
  localparam int HALF_W      = 28;
  localparam int SUBKEY_W    = 48;
  localparam int ROUND_W     = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [ROUND_W-1:0] LAST_ROUND = 4'd15;

  localparam int unsigned PC1_TBL [CD_W] = '{
    57, 49, 41, 33, 25, 17,  9,
     1, 58, 50, 42, 34, 26, 18,
    10,  2, 59, 51, 43, 35, 27,
    19, 11,  3, 60, 52, 44, 36,
    63, 55, 47, 39, 31, 23, 15,
     7, 62, 54, 46, 38, 30, 22,
    14,  6, 61, 53, 45, 37, 29,
    21, 13,  5, 28, 20, 12,  4
  };

  localparam int unsigned PC2_TBL [SUBKEY_W] = '{
    14, 17, 11, 24,  1,  5,
     3, 28, 15,  6, 21, 10,
    23, 19, 12,  4, 26,  8,
    16,  7, 27, 20, 13,  2,
    41, 52, 31, 37, 47, 55,
    30, 40, 51, 45, 33, 48,
    44, 49, 39, 56, 34, 53,
    46, 42, 50, 36, 29, 32
  };

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic               busy;
    logic [ROUND_W-1:0] round;
  } back_stat_t;

  function automatic logic [CD_W-1:0] pc1(input logic [KEY_W-1:0] k);
    logic [CD_W-1:0] s;
    s = '0;
    for (int i = 0; i < CD_W; i++) begin
      s[CD_W-1-i] = k[KEY_W-PC1_TBL[i]];
    end
    return s;
  endfunction

  function automatic logic [SUBKEY_W-1:0] pc2(input logic [CD_W-1:0] cd);
    logic [SUBKEY_W-1:0] s;
    s = '0;
    for (int i = 0; i < SUBKEY_W; i++) begin
      s[SUBKEY_W-1-i] = cd[CD_W-PC2_TBL[i]];
    end
    return s;
  endfunction

  function automatic logic single_shift(input logic [ROUND_W-1:0] r);
    return (r == 4'd0) || (r == 4'd1) || (r == 4'd8) || (r == LAST_ROUND);
  endfunction

  function automatic logic [HALF_W-1:0] rot_half(input logic [HALF_W-1:0] x,
                                                 input logic two);
    return two ? {x[HALF_W-3:0], x[HALF_W-1:HALF_W-2]} : {x[HALF_W-2:0], x[HALF_W-1]};
  endfunction

endpackage

>>> rtl/core/dks_if.sv
interface dks_key_if;
  logic                      valid;
  logic                      ready;
  logic [dks_pkg::KEY_W-1:0] key;

  modport source (output valid, output key, input ready);
  modport sink   (input valid, input key, output ready);
endinterface

interface dks_sub_if;
  logic                         valid;
  logic                         ready;
  logic [dks_pkg::SUBKEY_W-1:0] subkey;
  logic [dks_pkg::ROUND_W-1:0]  round;
  logic                         last;

  modport source (output valid, output subkey, output round, output last, input ready);
  modport sink   (input valid, input subkey, input round, input last, output ready);
endinterface

>>> rtl/core/dks_front.sv
module dks_front (
  input  logic                     clk,
  input  logic                     rst_n,
  dks_key_if.sink                  in_chan,
  output logic                     push_valid,
  output logic [dks_pkg::CD_W-1:0] push_cd,
  input  dks_pkg::q_stat_t         q_stat
);

  logic                     valid_r;
  logic [dks_pkg::CD_W-1:0] cd_r;
  logic                     in_fire;
  logic                     push_fire;

  assign push_fire     = valid_r && !q_stat.full;
  assign in_chan.ready = !valid_r || !q_stat.full;
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign push_valid    = valid_r;
  assign push_cd       = cd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_fire) begin
      valid_r <= 1'b1;
    end else if (push_fire) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cd_r <= dks_pkg::pc1(in_chan.key);
    end
  end

endmodule

>>> rtl/core/dks_queue.sv
module dks_queue #(
  parameter int DEPTH = dks_pkg::QUEUE_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  logic [dks_pkg::CD_W-1:0] push_cd,
  input  logic                     pop,
  output logic [dks_pkg::CD_W-1:0] pop_cd,
  output dks_pkg::q_stat_t         q_stat
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [dks_pkg::CD_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]         wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [dks_pkg::CD_W-1:0] head_r;
  logic                     do_push, do_pop;

  assign q_stat.full  = (count_r == CNT_W'(DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign pop_cd       = head_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // head register prefetches the next entry, with bypass when it is written now
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_cd;
    end
    if (do_push && (wr_ptr_r == rd_ptr_nxt)) begin
      head_r <= push_cd;
    end else begin
      head_r <= mem[rd_ptr_nxt];
    end
  end

endmodule

>>> rtl/core/dks_back.sv
module dks_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_empty,
  input  logic [dks_pkg::CD_W-1:0] pop_cd,
  output logic                     pop,
  dks_sub_if.source                out_chan,
  output dks_pkg::back_stat_t      stat
);

  logic                           busy_r;
  logic [dks_pkg::ROUND_W-1:0]    round_r;
  logic [dks_pkg::HALF_W-1:0]     c_r, d_r;
  logic [dks_pkg::HALF_W-1:0]     c_nxt, d_nxt;
  logic [dks_pkg::CD_W-1:0]       src;
  logic                           out_valid_r;
  logic [dks_pkg::SUBKEY_W-1:0]   subkey_r;
  logic [dks_pkg::ROUND_W-1:0]    out_round_r;
  logic                           last_r;
  logic                           load_ok;
  logic                           step;
  logic                           two;

  assign load_ok = !out_valid_r || out_chan.ready;
  assign step    = load_ok && (busy_r || !q_empty);
  assign pop     = step && !busy_r;

  assign src   = busy_r ? {c_r, d_r} : pop_cd;
  assign two   = !dks_pkg::single_shift(round_r);
  assign c_nxt = dks_pkg::rot_half(src[dks_pkg::CD_W-1:dks_pkg::HALF_W], two);
  assign d_nxt = dks_pkg::rot_half(src[dks_pkg::HALF_W-1:0], two);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      round_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (step) begin
        busy_r      <= (round_r != dks_pkg::LAST_ROUND);
        round_r     <= round_r + 1'b1;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      c_r         <= c_nxt;
      d_r         <= d_nxt;
      subkey_r    <= dks_pkg::pc2({c_nxt, d_nxt});
      out_round_r <= round_r;
      last_r      <= (round_r == dks_pkg::LAST_ROUND);
    end
  end

  assign out_chan.valid  = out_valid_r;
  assign out_chan.subkey = subkey_r;
  assign out_chan.round  = out_round_r;
  assign out_chan.last   = last_r;

  assign stat.busy  = busy_r;
  assign stat.round = round_r;

endmodule

>>> rtl/core/des_key_schedule_unit.sv
// channel   dir  payload                      items
// in_chan   in   key[63:0]                    one key
// out_chan  out  subkey[47:0] round[3:0] last sixteen subkeys per key
//
// One subkey leaves per cycle while out_chan is ready and a key is in the engine
// or queue; the round engine takes no new key until it is through with the last.
// It pops the next key on the step after round 15, so while a key waits in the
// queue the stream has no gap. Path: PC-1 reg, queue head, output reg.
// rst_n is synchronous; it empties the queue and idles the round engine.
// A stall on out_chan freezes the engine; keys keep entering until the queue and the PC-1 reg fill.
module des_key_schedule_unit #(
  parameter int QUEUE_DEPTH = dks_pkg::QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  dks_key_if.sink   in_chan,
  dks_sub_if.source out_chan
);

  logic                     push_valid;
  logic [dks_pkg::CD_W-1:0] push_cd;
  logic                     pop;
  logic [dks_pkg::CD_W-1:0] pop_cd;
  dks_pkg::q_stat_t         q_stat;
  dks_pkg::back_stat_t      b_stat;

  dks_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .push_valid (push_valid),
    .push_cd    (push_cd),
    .q_stat     (q_stat)
  );

  dks_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push_valid),
    .push_cd (push_cd),
    .pop     (pop),
    .pop_cd  (pop_cd),
    .q_stat  (q_stat)
  );

  dks_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_stat.empty),
    .pop_cd   (pop_cd),
    .pop      (pop),
    .out_chan (out_chan),
    .stat     (b_stat)
  );

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  a_idle_round_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !b_stat.busy |-> (b_stat.round == '0))
    else $error("round counter not cleared when idle");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.last) |->
      (!b_stat.busy && (out_chan.round == dks_pkg::LAST_ROUND)))
    else $error("last subkey shown while engine busy or wrong round");

  a_pop_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !q_stat.empty) |=> (b_stat.busy && (b_stat.round == 4'd1)))
    else $error("new key did not start at round zero");

endmodule

>>> tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_OFF_CYCLES = 300;
  localparam int HOLD_OFF_AT     = 40;
  localparam int RANDOM_KEYS     = 243;
  localparam int DRAIN_CYCLES    = 24;

  localparam int unsigned CHOICE1 [56] = '{
    57, 49, 41, 33, 25, 17,  9,
     1, 58, 50, 42, 34, 26, 18,
    10,  2, 59, 51, 43, 35, 27,
    19, 11,  3, 60, 52, 44, 36,
    63, 55, 47, 39, 31, 23, 15,
     7, 62, 54, 46, 38, 30, 22,
    14,  6, 61, 53, 45, 37, 29,
    21, 13,  5, 28, 20, 12,  4
  };

  localparam int unsigned CHOICE2 [48] = '{
    14, 17, 11, 24,  1,  5,
     3, 28, 15,  6, 21, 10,
    23, 19, 12,  4, 26,  8,
    16,  7, 27, 20, 13,  2,
    41, 52, 31, 37, 47, 55,
    30, 40, 51, 45, 33, 48,
    44, 49, 39, 56, 34, 53,
    46, 42, 50, 36, 29, 32
  };

  typedef struct packed {
    logic [dks_pkg::SUBKEY_W-1:0] subkey;
    logic [dks_pkg::ROUND_W-1:0]  round;
    logic                         last;
  } subkey_t;

  // flat: every round key of this key equals flat_key (typed in, not predicted)
  typedef struct packed {
    logic [dks_pkg::KEY_W-1:0]    key;
    logic                         flat;
    logic [dks_pkg::SUBKEY_W-1:0] flat_key;
  } key_row_t;

  localparam int NUM_DIR = 17;
  localparam key_row_t DIR_ROWS [NUM_DIR] = '{
    '{64'h0000_0000_0000_0000, 1'b1, 48'h0000_0000_0000},
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 48'hFFFF_FFFF_FFFF},
    '{64'h0101_0101_0101_0101, 1'b1, 48'h0000_0000_0000},  // parity bits only
    '{64'hFEFE_FEFE_FEFE_FEFE, 1'b1, 48'hFFFF_FFFF_FFFF},  // all but parity
    '{64'h0000_0000_0000_0001, 1'b1, 48'h0000_0000_0000},
    '{64'h8000_0000_0000_0000, 1'b0, 48'h0},
    '{64'h0000_0000_0000_0002, 1'b0, 48'h0},
    '{64'h1334_5779_9BBC_DFF1, 1'b0, 48'h0},
    '{64'h1F1F_1F1F_0E0E_0E0E, 1'b0, 48'h0},               // weak
    '{64'hE0E0_E0E0_F1F1_F1F1, 1'b0, 48'h0},               // weak
    '{64'h01FE_01FE_01FE_01FE, 1'b0, 48'h0},               // semi-weak
    '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 48'h0},
    '{64'h5555_5555_5555_5555, 1'b0, 48'h0},
    '{64'hFFFF_FFFF_0000_0000, 1'b0, 48'h0},
    '{64'h0000_0000_FFFF_FFFF, 1'b0, 48'h0},
    '{64'h0123_4567_89AB_CDEF, 1'b0, 48'h0},
    '{64'hFEDC_BA98_7654_3210, 1'b0, 48'h0}
  };

  logic clk;
  logic rst_n;

  dks_key_if key_ch ();
  dks_sub_if sub_ch ();

  des_key_schedule_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (key_ch),
    .out_chan (sub_ch)
  );

  subkey_t  exp_subkeys [$];
  key_row_t key_plans [$];
  int       errors = 0;
  int       checked = 0;
  int       keys_sent = 0;
  bit       no_idle = 1'b0;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic int idle_cycles();
    return no_idle ? 0 : $urandom_range(0, 4);
  endfunction

  function automatic void queue_subkeys(input logic [dks_pkg::KEY_W-1:0] k);
    logic [dks_pkg::CD_W-1:0]     perm;
    logic [dks_pkg::HALF_W-1:0]   c;
    logic [dks_pkg::HALF_W-1:0]   d;
    logic [dks_pkg::CD_W-1:0]     cd;
    logic [dks_pkg::SUBKEY_W-1:0] sk;
    int                           nrot;
    for (int i = 0; i < 56; i++) perm[55-i] = k[64-CHOICE1[i]];
    c = perm[55:28];
    d = perm[27:0];
    for (int r = 0; r < 16; r++) begin
      nrot = (r == 0 || r == 1 || r == 8 || r == 15) ? 1 : 2;
      repeat (nrot) begin
        c = {c[26:0], c[27]};
        d = {d[26:0], d[27]};
      end
      cd = {c, d};
      for (int i = 0; i < 48; i++) sk[47-i] = cd[56-CHOICE2[i]];
      exp_subkeys.push_back('{sk, r[dks_pkg::ROUND_W-1:0], r == 15});
    end
  endfunction

  // scoreboard: check outgoing subkeys first, then queue the ones of a new key
  always @(posedge clk) begin
    subkey_t  want;
    key_row_t plan;
    if (rst_n) begin
      if (sub_ch.valid && sub_ch.ready) begin
        checked++;
        if (exp_subkeys.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t unexpected subkey %h round %0d last %b", $realtime,
                     sub_ch.subkey, sub_ch.round, sub_ch.last);
        end else begin
          want = exp_subkeys.pop_front();
          if (sub_ch.subkey !== want.subkey || sub_ch.round !== want.round ||
              sub_ch.last !== want.last) begin
            errors++;
            if (errors <= 10)
              $display("%0t mismatch: exp %h/%0d/%b got %h/%0d/%b", $realtime,
                       want.subkey, want.round, want.last,
                       sub_ch.subkey, sub_ch.round, sub_ch.last);
          end
        end
      end
      if (key_ch.valid && key_ch.ready) begin
        plan = key_plans.pop_front();
        if (plan.flat) begin
          for (int r = 0; r < 16; r++)
            exp_subkeys.push_back('{plan.flat_key, r[dks_pkg::ROUND_W-1:0], r == 15});
        end else begin
          queue_subkeys(key_ch.key);
        end
      end
    end
  end

  task automatic send_key(input key_row_t row);
    int gap;
    gap = idle_cycles();
    key_plans.push_back(row);
    if (gap != 0) begin
      key_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    key_ch.valid <= 1'b1;
    key_ch.key   <= row.key;
    do @(posedge clk); while (!key_ch.ready);
    keys_sent++;
  endtask

  function automatic logic [dks_pkg::KEY_W-1:0] random_key();
    logic [dks_pkg::KEY_W-1:0] k;
    k = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      1: k = 64'h1 << $urandom_range(0, 63);
      2: k = ~(64'h1 << $urandom_range(0, 63));
      3: k = {8{k[7:0]}};
      default: ;
    endcase
    return k;
  endfunction

  // receiver; one long hold-off so the key queue fills and stalls the input
  initial begin
    int stall;
    int taken;
    taken = 0;
    sub_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = (taken == HOLD_OFF_AT) ? HOLD_OFF_CYCLES : idle_cycles();
      if (stall != 0) begin
        sub_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      sub_ch.ready <= 1'b1;
      do @(posedge clk); while (!sub_ch.valid);
      taken++;
    end
  end

  initial begin
    key_ch.valid = 1'b0;
    key_ch.key   = '0;
    rst_n        = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NUM_DIR; i++) send_key(DIR_ROWS[i]);

    for (int i = 0; i < RANDOM_KEYS; i++) begin
      if (i % 20 == 0) no_idle = ($urandom_range(0, 3) == 0);
      send_key('{random_key(), 1'b0, 48'h0});
    end
    key_ch.valid <= 1'b0;
    @(posedge clk);

    while (exp_subkeys.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run: %0d keys (zero/ones/parity-only, weak and semi-weak, random), %0d subkeys",
             keys_sent, checked);
    $display("checked; receiver held off %0d cycles once to back up the key queue",
             HOLD_OFF_CYCLES);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout");
    $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> files.f
rtl/core/dks_pkg.sv
rtl/core/dks_if.sv
rtl/core/dks_front.sv
rtl/core/dks_queue.sv
rtl/core/dks_back.sv
rtl/core/des_key_schedule_unit.sv
tb/testbench.sv
